[rtl/core/lldp_pkg.sv]
// Package: shared types and constants for the least-loaded device picker.
`timescale 1ns / 1ps

package lldp_pkg;

   localparam int LOAD_W   = 16;
   localparam int MEM_W    = 20;
   localparam int DEV_W    = 2;
   localparam int STATUS_W = 3;
   localparam int ACTIVE_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int LIMIT_REGS = 4;

   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
   localparam logic [MEM_W-1:0]  MEM_MAX  = '1;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_ASSIGNED = 3'd0;
   localparam status_type ST_NO_FIT   = 3'd1;
   localparam status_type ST_RELEASED = 3'd2;
   localparam status_type ST_BAD_DEV  = 3'd3;
   localparam status_type ST_CLAMPED  = 3'd4;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_ACTIVE = 3'd0;
   localparam csr_idx_type CSR_LIMIT0 = 3'd1;
   localparam csr_idx_type CSR_LIMIT3 = 3'd4;

   typedef struct packed {
      logic              en;
      logic [DEV_W-1:0]  idx;
      logic [LOAD_W-1:0] load;
      logic [MEM_W-1:0]  mem;
   } tbl_wr_type;

   typedef struct packed {
      logic             fit;
      logic             less;
      logic             under;
      logic [MEM_W-1:0] sum;
      logic [MEM_W-1:0] diff;
   } alu_res_type;

endpackage

[rtl/core/lldp_alu.sv]
// Shared fit/compare unit: memory fit test, sum, difference and load compare.
`timescale 1ns / 1ps

module lldp_alu (
   input  logic [lldp_pkg::MEM_W-1:0]  used,
   input  logic [lldp_pkg::MEM_W-1:0]  amount,
   input  logic [lldp_pkg::MEM_W-1:0]  limit,
   input  logic [lldp_pkg::LOAD_W-1:0] load_a,
   input  logic [lldp_pkg::LOAD_W-1:0] load_b,
   output lldp_pkg::alu_res_type       res
);
   import lldp_pkg::*;

   logic [MEM_W:0] sum_wide;

   always_comb begin
      sum_wide  = {1'b0, used} + {1'b0, amount};
      res.sum   = sum_wide[MEM_W-1:0];
      res.fit   = (sum_wide <= {1'b0, limit});
      res.under = (amount > used);
      res.diff  = used - amount;
      res.less  = (load_a < load_b);
   end

endmodule

[rtl/core/lldp_table.sv]
// Per-device task count and memory usage registers, one read and one write port.
`timescale 1ns / 1ps

module lldp_table #(
   parameter int DEVICES = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lldp_pkg::DEV_W-1:0]  rd_idx,
   input  lldp_pkg::tbl_wr_type        wr,
   output logic [lldp_pkg::LOAD_W-1:0] rd_load,
   output logic [lldp_pkg::MEM_W-1:0]  rd_mem
);
   import lldp_pkg::*;

   localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

   logic [LOAD_W-1:0] load_ff [DEVICES];
   logic [MEM_W-1:0]  mem_ff  [DEVICES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEVICES; i++) begin
            load_ff[i] <= '0;
            mem_ff[i]  <= '0;
         end
      end else if (wr.en) begin
         load_ff[wr.idx[IDX_W-1:0]] <= wr.load;
         mem_ff[wr.idx[IDX_W-1:0]]  <= wr.mem;
      end
   end

   assign rd_load = load_ff[rd_idx[IDX_W-1:0]];
   assign rd_mem  = mem_ff[rd_idx[IDX_W-1:0]];

endmodule

[rtl/core/least_loaded_device_picker.sv]
// Top level: least-loaded device picker with sequencer, config registers and result register.
//
//   channel  prefix  direction  contents
//   request  req_    in         kind, memory_amount, release_device
//   result   rsp_    out        status, chosen_device, device_load, device_memory, least_loaded
//   config   csr_    in         index 0 active_devices, 1..4 limit_device0..3
//
// Assign: FIT scan of the N active devices, APPLY, RANK scan, FINISH loads the result; release skips FIT.
// The next request is taken once the sequencer is back in IDLE after the result loads.
// One device per cycle through the shared fit/compare unit in each scan.
// Reset clears counts, usage, config to defaults; csr writes are taken only while idle.
// A request is taken only between items; a waiting result holds the sequencer.
`timescale 1ns / 1ps

module least_loaded_device_picker #(
   parameter int DEVICES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [lldp_pkg::MEM_W-1:0]      req_memory_amount,
   input  logic [lldp_pkg::DEV_W-1:0]      req_release_device,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lldp_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lldp_pkg::DEV_W-1:0]      rsp_chosen_device,
   output logic [lldp_pkg::LOAD_W-1:0]     rsp_device_load,
   output logic [lldp_pkg::MEM_W-1:0]      rsp_device_memory,
   output logic [lldp_pkg::DEV_W-1:0]      rsp_least_loaded,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lldp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lldp_pkg::MEM_W-1:0]      csr_data
);
   import lldp_pkg::*;

   localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int CNT_W = $clog2(DEVICES + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_FIT    = 5'b00010,
      S_APPLY  = 5'b00100,
      S_RANK   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                kind_ff, kind_in;
   logic [MEM_W-1:0]    amount_ff, amount_in;
   logic [DEV_W-1:0]    rdev_ff, rdev_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [LOAD_W-1:0]   best_load_ff, best_load_in;
   logic [IDX_W-1:0]    rank_ff, rank_in;
   logic [LOAD_W-1:0]   rank_load_ff, rank_load_in;
   status_type          res_status_ff, res_status_in;
   logic [DEV_W-1:0]    res_dev_ff, res_dev_in;
   logic [LOAD_W-1:0]   res_load_ff, res_load_in;
   logic [MEM_W-1:0]    res_mem_ff, res_mem_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DEV_W-1:0]    rsp_dev_ff, rsp_dev_in;
   logic [LOAD_W-1:0]   rsp_load_ff, rsp_load_in;
   logic [MEM_W-1:0]    rsp_mem_ff, rsp_mem_in;
   logic [DEV_W-1:0]    rsp_least_ff, rsp_least_in;

   logic [ACTIVE_W-1:0] active_ff;
   logic [MEM_W-1:0]    limit_ff [LIMIT_REGS];

   logic [CNT_W-1:0]    act_n;
   logic                last;
   logic                bad_dev;
   logic [IDX_W-1:0]    scan_idx;
   logic [IDX_W-1:0]    target;
   logic [DEV_W-1:0]    rd_idx;
   logic [LOAD_W-1:0]   rd_load;
   logic [MEM_W-1:0]    rd_mem;
   logic [LOAD_W-1:0]   cmp_load;
   tbl_wr_type          wr;
   alu_res_type         alu;
   logic                req_take;
   logic                rsp_load_en;

   // Config registers, written only between requests
   assign csr_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_W'(4);
         for (int i = 0; i < LIMIT_REGS; i++) begin
            limit_ff[i] <= MEM_MAX;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_ACTIVE) begin
            active_ff <= csr_data[ACTIVE_W-1:0];
         end else if (csr_index >= CSR_LIMIT0 && csr_index <= CSR_LIMIT3) begin
            limit_ff[2'(csr_index - CSR_LIMIT0)] <= csr_data;
         end
      end
   end

   // Active device count clamped to 1..DEVICES
   always_comb begin
      if (active_ff == '0) begin
         act_n = CNT_W'(1);
      end else if (active_ff > ACTIVE_W'(DEVICES)) begin
         act_n = CNT_W'(DEVICES);
      end else begin
         act_n = CNT_W'(active_ff);
      end
   end

   assign last     = (cnt_ff == act_n - CNT_W'(1));
   assign bad_dev  = ({1'b0, rdev_ff} >= ACTIVE_W'(act_n));
   assign scan_idx = cnt_ff[IDX_W-1:0];
   assign target   = kind_ff ? rdev_ff[IDX_W-1:0] : best_ff;
   assign rd_idx   = (state_ff == S_APPLY) ? DEV_W'(target) : DEV_W'(scan_idx);
   assign cmp_load = (state_ff == S_FIT) ? best_load_ff : rank_load_ff;

   lldp_table #(
      .DEVICES(DEVICES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .wr      (wr),
      .rd_load (rd_load),
      .rd_mem  (rd_mem)
   );

   lldp_alu u_alu (
      .used   (rd_mem),
      .amount (amount_ff),
      .limit  (limit_ff[rd_idx]),
      .load_a (rd_load),
      .load_b (cmp_load),
      .res    (alu)
   );

   assign req_take    = req_valid && req_ready;
   assign rsp_load_en = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      kind_in       = kind_ff;
      amount_in     = amount_ff;
      rdev_in       = rdev_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_load_in  = best_load_ff;
      rank_in       = rank_ff;
      rank_load_in  = rank_load_ff;
      res_status_in = res_status_ff;
      res_dev_in    = res_dev_ff;
      res_load_in   = res_load_ff;
      res_mem_in    = res_mem_ff;
      wr            = '0;
      req_ready     = (state_ff == S_IDLE) && !csr_valid;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               kind_in   = req_kind;
               amount_in = req_memory_amount;
               rdev_in   = req_release_device;
               cnt_in    = '0;
               found_in  = 1'b0;
               state_in  = req_kind ? S_APPLY : S_FIT;
            end
         end
         S_FIT: begin
            if (alu.fit && (!found_ff || alu.less)) begin
               found_in     = 1'b1;
               best_in      = scan_idx;
               best_load_in = rd_load;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (last) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            res_status_in = ST_NO_FIT;
            res_dev_in    = '0;
            res_load_in   = '0;
            res_mem_in    = '0;
            wr.idx        = DEV_W'(target);
            if (!kind_ff) begin
               if (found_ff) begin
                  wr.en         = 1'b1;
                  wr.load       = (rd_load == LOAD_MAX) ? rd_load : rd_load + LOAD_W'(1);
                  wr.mem        = alu.sum;
                  res_status_in = ST_ASSIGNED;
               end
            end else if (bad_dev) begin
               res_status_in = ST_BAD_DEV;
            end else begin
               wr.en         = 1'b1;
               wr.load       = (rd_load == '0) ? rd_load : rd_load - LOAD_W'(1);
               wr.mem        = alu.under ? '0 : alu.diff;
               res_status_in = alu.under ? ST_CLAMPED : ST_RELEASED;
            end
            if (wr.en) begin
               res_dev_in  = DEV_W'(target);
               res_load_in = wr.load;
               res_mem_in  = wr.mem;
            end
            cnt_in   = '0;
            state_in = S_RANK;
         end
         S_RANK: begin
            if (cnt_ff == '0 || alu.less) begin
               rank_in      = scan_idx;
               rank_load_in = rd_load;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_load_en) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dev_in    = rsp_dev_ff;
      rsp_load_in   = rsp_load_ff;
      rsp_mem_in    = rsp_mem_ff;
      rsp_least_in  = rsp_least_ff;
      if (rsp_load_en) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_dev_in    = res_dev_ff;
         rsp_load_in   = res_load_ff;
         rsp_mem_in    = res_mem_ff;
         rsp_least_in  = DEV_W'(rank_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      amount_ff     <= amount_in;
      rdev_ff       <= rdev_in;
      best_ff       <= best_in;
      best_load_ff  <= best_load_in;
      rank_ff       <= rank_in;
      rank_load_ff  <= rank_load_in;
      res_status_ff <= res_status_in;
      res_dev_ff    <= res_dev_in;
      res_load_ff   <= res_load_in;
      res_mem_ff    <= res_mem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dev_ff    <= rsp_dev_in;
      rsp_load_ff   <= rsp_load_in;
      rsp_mem_ff    <= rsp_mem_in;
      rsp_least_ff  <= rsp_least_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_chosen_device = rsp_dev_ff;
   assign rsp_device_load   = rsp_load_ff;
   assign rsp_device_memory = rsp_mem_ff;
   assign rsp_least_loaded  = rsp_least_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIT || state_ff == S_RANK) |-> (cnt_ff < act_n))
      else $error("scan index beyond active devices");

   a_assign_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RANK && res_status_ff == ST_ASSIGNED)
         |-> (res_mem_ff <= limit_ff[res_dev_ff]))
      else $error("assigned usage exceeds device limit");

   a_no_fit_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && !kind_ff && !found_ff) |-> !wr.en)
      else $error("table written without a fitting device");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_load_en |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not presented after finish");

endmodule

[dv/picker_check_pkg.sv]
// Scoreboard package: device load/memory tracker that predicts and checks picker results.
`timescale 1ns / 1ps

package picker_check_pkg;

   import lldp_pkg::*;

   localparam int DEVICE_SLOTS = 4;
   localparam int REPORT_LIMIT = 10;

   localparam logic KIND_ASSIGN  = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      status_type        status;
      logic [DEV_W-1:0]  device;
      logic [LOAD_W-1:0] load;
      logic [MEM_W-1:0]  memory;
      logic [DEV_W-1:0]  least;
   } pick_result_type;

   class placement_scoreboard;

      logic [ACTIVE_W-1:0] active_reg;
      logic [MEM_W-1:0]    limit_mib [LIMIT_REGS];
      logic [LOAD_W-1:0]   task_total [DEVICE_SLOTS];
      logic [MEM_W-1:0]    mem_used [DEVICE_SLOTS];
      pick_result_type     expected_results [$];
      int                  mismatches;

      function new();
         active_reg = ACTIVE_W'(4);
         for (int i = 0; i < LIMIT_REGS; i++) limit_mib[i] = MEM_MAX;
         for (int i = 0; i < DEVICE_SLOTS; i++) begin
            task_total[i] = '0;
            mem_used[i]   = '0;
         end
         mismatches = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [MEM_W-1:0] data);
         if (idx == CSR_ACTIVE) begin
            active_reg = data[ACTIVE_W-1:0];
         end else if (idx >= CSR_LIMIT0 && idx <= CSR_LIMIT3) begin
            limit_mib[idx - CSR_LIMIT0] = data;
         end
      endfunction

      function int active_span();
         int n;
         n = active_reg;
         if (n < 1) n = 1;
         if (n > DEVICE_SLOTS) n = DEVICE_SLOTS;
         return n;
      endfunction

      function logic [LOAD_W-1:0] tasks_of(int dev);
         return task_total[dev];
      endfunction

      function logic [MEM_W-1:0] usage_of(int dev);
         return mem_used[dev];
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_request(logic kind, logic [MEM_W-1:0] amount, logic [DEV_W-1:0] dev);
         pick_result_type r;
         int              n;
         int              best;
         bit              found;
         logic [MEM_W:0]  total;
         r = '0;
         n = active_span();
         if (kind == KIND_ASSIGN) begin
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < n; i++) begin
               total = {1'b0, mem_used[i]} + {1'b0, amount};
               if (total <= {1'b0, limit_mib[i]} &&
                   (!found || task_total[i] < task_total[best])) begin
                  best  = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               if (task_total[best] != LOAD_MAX) task_total[best]++;
               mem_used[best] = mem_used[best] + amount;
               r.status = ST_ASSIGNED;
               r.device = DEV_W'(best);
               r.load   = task_total[best];
               r.memory = mem_used[best];
            end else begin
               r.status = ST_NO_FIT;
            end
         end else if (int'(dev) >= n) begin
            r.status = ST_BAD_DEV;
         end else begin
            if (task_total[dev] != 0) task_total[dev]--;
            if (amount > mem_used[dev]) begin
               mem_used[dev] = '0;
               r.status = ST_CLAMPED;
            end else begin
               mem_used[dev] = mem_used[dev] - amount;
               r.status = ST_RELEASED;
            end
            r.device = dev;
            r.load   = task_total[dev];
            r.memory = mem_used[dev];
         end
         // least-loaded is judged after the update
         best = 0;
         for (int i = 1; i < n; i++) if (task_total[i] < task_total[best]) best = i;
         r.least = DEV_W'(best);
         expected_results.push_back(r);
      endfunction

      function void check_result(pick_result_type got);
         pick_result_type want;
         bit              bad;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: status=%0d device=%0d load=%0d memory=%0d least=%0d",
                        got.status, got.device, got.load, got.memory, got.least);
            return;
         end
         want = expected_results.pop_front();
         bad = (got.status !== want.status) || (got.device !== want.device) ||
               (got.load !== want.load) || (got.memory !== want.memory) ||
               (got.least !== want.least);
         if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("mismatch: expected status=%0d device=%0d load=%0d memory=%0d least=%0d",
                        want.status, want.device, want.load, want.memory, want.least);
               $display("          actual   status=%0d device=%0d load=%0d memory=%0d least=%0d",
                        got.status, got.device, got.load, got.memory, got.least);
            end
         end
      endfunction

   endclass

endpackage

[dv/least_loaded_device_picker_tb.sv]
// Testbench top: drives assign/release requests and register writes, checks every result.
`timescale 1ns / 1ps

module least_loaded_device_picker_tb;

   import lldp_pkg::*;
   import picker_check_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_kind = KIND_ASSIGN;
   logic [MEM_W-1:0]     req_memory_amount = '0;
   logic [DEV_W-1:0]     req_release_device = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [DEV_W-1:0]     rsp_chosen_device;
   logic [LOAD_W-1:0]    rsp_device_load;
   logic [MEM_W-1:0]     rsp_device_memory;
   logic [DEV_W-1:0]     rsp_least_loaded;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ACTIVE;
   logic [MEM_W-1:0]     csr_data = '0;

   placement_scoreboard sb = new();

   bit gaps_on      = 1'b0;
   bit rsp_throttle = 1'b0;
   int stall_left   = 0;
   int cycle_count  = 0;

   least_loaded_device_picker i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_memory_amount  (req_memory_amount),
      .req_release_device (req_release_device),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_chosen_device  (rsp_chosen_device),
      .rsp_device_load    (rsp_device_load),
      .rsp_device_memory  (rsp_device_memory),
      .rsp_least_loaded   (rsp_least_loaded),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("least_loaded_device_picker_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_result(pick_result_type'({rsp_status, rsp_chosen_device, rsp_device_load,
                                            rsp_device_memory, rsp_least_loaded}));
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (stall_left == 0 && rsp_throttle && $urandom_range(0, 3) == 0)
         stall_left = pick_gap() + 1;
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   function automatic csr_idx_type limit_reg(int i);
      return csr_idx_type'(CSR_LIMIT0 + i);
   endfunction

   // indexes past the last limit register
   function automatic csr_idx_type spare_reg(int k);
      return csr_idx_type'(CSR_LIMIT3 + k);
   endfunction

   // all tasks below are entered and left just after a falling edge
   task automatic send_request(logic kind, logic [MEM_W-1:0] amount, logic [DEV_W-1:0] dev);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          = 1'b1;
      req_kind           = kind;
      req_memory_amount  = amount;
      req_release_device = dev;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, amount, dev);
      @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [MEM_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic run_directed();
      gaps_on      = 1'b1;
      rsp_throttle = 1'b1;
      // default setup: four devices, full limits
      send_request(KIND_ASSIGN, '0, 2'd3);
      send_request(KIND_ASSIGN, MEM_MAX, 2'd0);
      send_request(KIND_ASSIGN, MEM_MAX, 2'd1);
      send_request(KIND_RELEASE, MEM_MAX, 2'd1);
      send_request(KIND_RELEASE, 20'd5, 2'd1);
      send_request(KIND_RELEASE, '0, 2'd3);
      send_request(KIND_RELEASE, 20'hAAAAA, 2'd2);
      send_request(KIND_ASSIGN, 20'h55555, 2'd2);
      wait_idle();
      write_csr(CSR_ACTIVE, 20'd2);
      write_csr(limit_reg(0), '0);
      write_csr(limit_reg(1), 20'd100);
      write_csr(limit_reg(2), MEM_MAX);
      write_csr(limit_reg(3), 20'h55555);
      send_request(KIND_ASSIGN, '0, 2'd1);
      send_request(KIND_ASSIGN, 20'd1, 2'd2);
      send_request(KIND_RELEASE, 20'h55555, 2'd1);
      send_request(KIND_ASSIGN, 20'd100, 2'd0);
      send_request(KIND_ASSIGN, 20'd1, 2'd3);
      send_request(KIND_ASSIGN, MEM_MAX, 2'd0);
      send_request(KIND_RELEASE, '0, 2'd2);
      send_request(KIND_RELEASE, '0, 2'd3);
      wait_idle();
      // zero active devices behaves as one
      write_csr(CSR_ACTIVE, '0);
      send_request(KIND_RELEASE, 20'd1, 2'd1);
      send_request(KIND_ASSIGN, '0, 2'd0);
      send_request(KIND_ASSIGN, 20'd1, 2'd0);
      wait_idle();
      // seven active devices behaves as four; upper data bits ignored
      write_csr(CSR_ACTIVE, MEM_MAX);
      write_csr(spare_reg(1), '0);
      send_request(KIND_ASSIGN, 20'h12345, 2'd0);
      send_request(KIND_RELEASE, 20'h12345, 2'd3);
      send_request(KIND_ASSIGN, '0, 2'd1);
   endtask

   function automatic logic [MEM_W-1:0] pick_limit();
      case ($urandom_range(0, 3))
         0: return MEM_MAX;
         1: return MEM_W'($urandom_range(0, 4095));
         2: return MEM_W'($urandom);
         default: return MEM_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic run_random_phase(int phase, int items);
      logic [ACTIVE_W-1:0] act;
      logic                kind;
      logic [MEM_W-1:0]    amount;
      logic [DEV_W-1:0]    dev;
      int                  n;
      int                  sel;
      wait_idle();
      gaps_on      = (phase % 4 != 2);
      rsp_throttle = (phase % 4 != 2);
      if (phase == 0) begin
         act = ACTIVE_W'(4);
      end else if (phase == 1) begin
         act = ACTIVE_W'(1);
      end else if ($urandom_range(0, 9) < 8) begin
         act = ACTIVE_W'($urandom_range(1, 4));
      end else begin
         act = ACTIVE_W'($urandom_range(0, 7));
      end
      write_csr(CSR_ACTIVE, {(MEM_W-ACTIVE_W)'($urandom), act});
      for (int i = 0; i < LIMIT_REGS; i++) begin
         if (phase == 0) write_csr(limit_reg(i), MEM_MAX);
         else if (phase == 1) write_csr(limit_reg(i), '0);
         else write_csr(limit_reg(i), pick_limit());
      end
      if ($urandom_range(0, 3) == 0)
         write_csr(spare_reg($urandom_range(1, 3)), MEM_W'($urandom));
      n = sb.active_span();
      for (int k = 0; k < items; k++) begin
         kind = ($urandom_range(0, 99) < 55) ? KIND_ASSIGN : KIND_RELEASE;
         sel  = $urandom_range(0, 9);
         if (kind == KIND_ASSIGN) begin
            dev = DEV_W'($urandom);
            if (sel < 6) amount = MEM_W'($urandom_range(0, 1023));
            else if (sel < 8) amount = MEM_W'($urandom);
            else if (sel == 8) amount = '0;
            else amount = MEM_MAX;
         end else begin
            if ($urandom_range(0, 99) < 85) dev = DEV_W'($urandom_range(0, n - 1));
            else dev = DEV_W'($urandom);
            if (sel < 7) amount = MEM_W'($urandom_range(0, sb.usage_of(dev)));
            else if (sel == 7) amount = sb.usage_of(dev);
            else if (sel == 8) amount = MEM_W'($urandom);
            else amount = MEM_MAX;
         end
         send_request(kind, amount, dev);
      end
   endtask

   task automatic run_saturation();
      wait_idle();
      gaps_on      = 1'b0;
      rsp_throttle = 1'b0;
      write_csr(CSR_ACTIVE, 20'd1);
      write_csr(limit_reg(0), MEM_MAX);
      repeat (40) send_request(KIND_ASSIGN, '0, DEV_W'($urandom));
      repeat (2) send_request(KIND_ASSIGN, 20'd1, DEV_W'($urandom));
      send_request(KIND_RELEASE, '0, 2'd0);
      send_request(KIND_RELEASE, '0, 2'd1);
      send_request(KIND_ASSIGN, '0, 2'd0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      for (int p = 0; p < 9; p++) run_random_phase(p, 75);
      run_saturation();
      wait_idle();
      repeat (30) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("least_loaded_device_picker_tb passed");
      end else begin
         $display("least_loaded_device_picker_tb failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/lldp_pkg.sv
rtl/core/lldp_alu.sv
rtl/core/lldp_table.sv
rtl/core/least_loaded_device_picker.sv
dv/picker_check_pkg.sv
dv/least_loaded_device_picker_tb.sv
